[src/fde_pkg.sv]
// Shared types and constants for the finite-difference extrapolator.
package fde_pkg;

  localparam int unsigned DATA_W   = 64;
  localparam int unsigned SAMPLE_W = 32;
  // Wide enough for a level count up to 127, the largest sequence length it can hold.
  localparam int unsigned CNT_W    = 7;

  typedef struct packed {
    logic              valid;
    logic              write;
    logic              last;
    logic              too_long;
    logic [CNT_W-1:0]  n;
    logic [DATA_W-1:0] d;
    logic [DATA_W-1:0] sum;
  } wave_t;

endpackage

[src/fde_entry.sv]
// Entry stage: tracks the sample count and overflow of the current sequence.
module fde_entry #(
  parameter int unsigned MAX_LEN = 32
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic [fde_pkg::SAMPLE_W-1:0]   sample_i,
  input  logic                           last_i,
  input  logic                           accept_i,
  output fde_pkg::wave_t                 wave_o
);
  import fde_pkg::*;

  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             ovf_q, ovf_d;
  logic             room;

  assign room = (cnt_q < CNT_W'(MAX_LEN));

  always_comb begin
    wave_o          = '0;
    wave_o.valid    = accept_i;
    wave_o.write    = room;
    wave_o.last     = last_i;
    wave_o.too_long = ovf_q | ~room;
    wave_o.n        = room ? (cnt_q + CNT_W'(1)) : CNT_W'(MAX_LEN);
    wave_o.d        = {{(DATA_W-SAMPLE_W){sample_i[SAMPLE_W-1]}}, sample_i};
    wave_o.sum      = '0;
  end

  always_comb begin
    cnt_d = cnt_q;
    ovf_d = ovf_q;
    if (accept_i) begin
      if (last_i) begin
        cnt_d = '0;
        ovf_d = 1'b0;
      end else if (room) begin
        cnt_d = cnt_q + CNT_W'(1);
      end else begin
        ovf_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      ovf_q <= 1'b0;
    end else begin
      cnt_q <= cnt_d;
      ovf_q <= ovf_d;
    end
  end

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CNT_W'(MAX_LEN))
    else $error("sample count beyond maximum length");

  a_ovf_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ovf_q |-> cnt_q == CNT_W'(MAX_LEN))
    else $error("overflow flagged before the levels were full");

endmodule

[src/fde_cell.sv]
// One difference level: holds its tail and passes the difference to the next level.
module fde_cell #(
  parameter int unsigned IDX = 0
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           en_i,
  input  fde_pkg::wave_t wave_i,
  output fde_pkg::wave_t wave_o
);
  import fde_pkg::*;

  logic [DATA_W-1:0] tail_q;
  wave_t             wave_q, wave_d;
  logic              active;

  assign active = wave_i.valid && (CNT_W'(IDX) < wave_i.n);

  always_comb begin
    wave_d = wave_i;
    if (active) begin
      if (wave_i.write) begin
        wave_d.sum = wave_i.sum + wave_i.d;
        wave_d.d   = wave_i.d - tail_q;
      end else begin
        wave_d.sum = wave_i.sum + tail_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i && active && wave_i.write) begin
      tail_q <= wave_i.d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wave_q <= '0;
    end else if (en_i) begin
      wave_q <= wave_d;
    end
  end

  assign wave_o = wave_q;

endmodule

[src/finite_difference_extrapolator.sv]
// Top level of the finite-difference extrapolator: cell chain and result stage.
//
//  Channel  Direction  Payload (low bit first)                          Beat meaning
//  s_axis   in         tdata: sample[31:0]; tlast: last                  one sample
//  m_axis   out        tdata: next_value, running_sum; tuser: too_long   one prediction
//
// One sample is accepted per cycle unless the output stalls. A sample passes one cell
// per cycle when enabled, then each prediction is registered at the output.
// Reset clears the sample count, overflow flag, running total and all valid bits.
// A result held at the output while the sink is not ready freezes the whole chain.
module finite_difference_extrapolator #(
  parameter int unsigned MAX_LEN = 32
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          s_axis_tvalid_i,
  output logic          s_axis_tready_o,
  input  logic [31:0]   s_axis_tdata_i,   // sample[31:0]
  input  logic          s_axis_tlast_i,
  output logic          m_axis_tvalid_o,
  input  logic          m_axis_tready_i,
  output logic [127:0]  m_axis_tdata_o,   // next_value[63:0], running_sum[127:64]
  output logic          m_axis_tuser_o    // too_long
);
  import fde_pkg::*;

  wave_t             wave [MAX_LEN+1];
  logic              stall, en, accept;
  logic              out_vld_q;
  logic [DATA_W-1:0] next_q, total_q, total_d;
  logic              too_long_q;
  logic              emit;

  assign stall           = out_vld_q && !m_axis_tready_i;
  assign en              = !stall;
  assign s_axis_tready_o = en;
  assign accept          = s_axis_tvalid_i && en;

  fde_entry #(.MAX_LEN(MAX_LEN)) u_entry (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .sample_i (s_axis_tdata_i),
    .last_i   (s_axis_tlast_i),
    .accept_i (accept),
    .wave_o   (wave[0])
  );

  for (genvar k = 0; k < MAX_LEN; k++) begin : g_cell
    fde_cell #(.IDX(k)) u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .en_i   (en),
      .wave_i (wave[k]),
      .wave_o (wave[k+1])
    );
  end

  assign emit    = wave[MAX_LEN].valid && wave[MAX_LEN].last;
  assign total_d = total_q + wave[MAX_LEN].sum;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
      total_q   <= '0;
    end else if (en) begin
      out_vld_q <= emit;
      if (emit) begin
        total_q <= total_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en && emit) begin
      next_q     <= wave[MAX_LEN].sum;
      too_long_q <= wave[MAX_LEN].too_long;
    end
  end

  assign m_axis_tvalid_o = out_vld_q;
  assign m_axis_tdata_o  = {total_q, next_q};
  assign m_axis_tuser_o  = too_long_q;

  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready_o |-> m_axis_tvalid_o && !m_axis_tready_i)
    else $error("input stalled without a blocked result");

  a_total_shown: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> m_axis_tdata_o[127:64] == total_q)
    else $error("running sum differs from the kept total");

  a_total_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid_o) |-> total_q == $past(total_q) + next_q)
    else $error("total did not advance by the prediction");

endmodule

[tb/finite_difference_extrapolator_tb.sv]
// Self-checking testbench for the finite-difference extrapolator stream block.
module finite_difference_extrapolator_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import fde_pkg::*;

  localparam int unsigned MAX_LEN      = 32;
  localparam int unsigned RANDOM_ITEMS = 870;
  localparam int unsigned CYCLE_LIMIT  = 200000;
  localparam int unsigned IDLE_PCT     = 22;
  localparam int unsigned HOLD_CYCLES  = 300;

  typedef struct packed {
    logic [DATA_W-1:0] next_value;
    logic [DATA_W-1:0] running_sum;
    logic              too_long;
  } prediction_t;

  typedef struct {
    logic [SAMPLE_W-1:0] sample;
    logic [SAMPLE_W-1:0] flip;
    int                  reps;
    bit                  ends_seq;
    bit                  typed;
    prediction_t         known;
  } stim_row_t;

  logic                clk_i;
  logic                rst_ni;
  logic                s_axis_tvalid;
  logic                s_axis_tready;
  logic [31:0]         s_axis_tdata;   // sample[31:0]
  logic                s_axis_tlast;
  logic                m_axis_tvalid;
  logic                m_axis_tready;
  logic [127:0]        m_axis_tdata;   // next_value[63:0], running_sum[127:64]
  logic                m_axis_tuser;   // too_long

  finite_difference_extrapolator #(
    .MAX_LEN(MAX_LEN)
  ) uut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid),
    .s_axis_tready_o (s_axis_tready),
    .s_axis_tdata_i  (s_axis_tdata),
    .s_axis_tlast_i  (s_axis_tlast),
    .m_axis_tvalid_o (m_axis_tvalid),
    .m_axis_tready_i (m_axis_tready),
    .m_axis_tdata_o  (m_axis_tdata),
    .m_axis_tuser_o  (m_axis_tuser)
  );

  logic [DATA_W-1:0] diff_tail [MAX_LEN];
  int unsigned       kept_samples;
  bit                dropped_sample;
  logic [DATA_W-1:0] prediction_total;

  prediction_t       pending_predictions [$];
  stim_row_t         directed_rows [$];
  int unsigned       mismatches;
  int unsigned       cycles;
  bit                calm;
  bit                hold_req;

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  initial begin
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycles++;
    end
    $display("finite_difference_extrapolator test failed");
    $finish;
  end

  task automatic predict_sample(input logic [SAMPLE_W-1:0] smp, input logic lst,
                                output bit emits, output prediction_t res);
    logic [DATA_W-1:0] d;
    logic [DATA_W-1:0] old;
    emits = 1'b0;
    res   = '0;
    if (kept_samples < MAX_LEN) begin
      d = {{(DATA_W-SAMPLE_W){smp[SAMPLE_W-1]}}, smp};
      for (int k = 0; k <= kept_samples; k++) begin
        old          = diff_tail[k];
        diff_tail[k] = d;
        d            = d - old;
      end
      kept_samples++;
    end else begin
      dropped_sample = 1'b1;
    end
    if (lst) begin
      for (int k = 0; k < kept_samples; k++) begin
        res.next_value += diff_tail[k];
      end
      prediction_total += res.next_value;
      res.running_sum   = prediction_total;
      res.too_long      = dropped_sample;
      emits             = 1'b1;
      kept_samples      = 0;
      dropped_sample    = 1'b0;
    end
  endtask

  task automatic report_mismatch(input string what, input logic [DATA_W-1:0] want,
                                 input logic [DATA_W-1:0] got);
    mismatches++;
    if (mismatches <= 10) begin
      $display("Mismatch in %s: expected %h, got %h", what, want, got);
    end
  endtask

  task automatic send_sample(input logic [SAMPLE_W-1:0] smp, input logic lst,
                             input bit typed, input prediction_t known);
    bit          sent;
    bit          emits;
    prediction_t res;
    sent = 1'b0;
    while (!sent) begin
      @(negedge clk_i);
      if (!calm && $urandom_range(99) < IDLE_PCT) begin
        s_axis_tvalid <= 1'b0;
      end else begin
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= smp;
        s_axis_tlast  <= lst;
        do @(posedge clk_i); while (!s_axis_tready);
        sent = 1'b1;
      end
    end
    predict_sample(smp, lst, emits, res);
    if (emits) begin
      pending_predictions.insert(pending_predictions.size(), typed ? known : res);
    end
  endtask

  task automatic add_row(input logic [SAMPLE_W-1:0] smp, input logic [SAMPLE_W-1:0] flip,
                         input int reps, input bit ends_seq, input bit typed,
                         input logic [DATA_W-1:0] nv, input logic [DATA_W-1:0] rs,
                         input logic tl);
    stim_row_t row;
    row.sample   = smp;
    row.flip     = flip;
    row.reps     = reps;
    row.ends_seq = ends_seq;
    row.typed    = typed;
    row.known    = '{next_value: nv, running_sum: rs, too_long: tl};
    directed_rows.insert(directed_rows.size(), row);
  endtask

  // Sink side: random back-pressure, a calm stretch, and one long hold-off on request.
  initial begin
    int hold_left;
    bit hold_done;
    hold_left     = 0;
    hold_done     = 1'b0;
    m_axis_tready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_req && !hold_done) begin
        hold_left = HOLD_CYCLES;
        hold_done = 1'b1;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= calm || ($urandom_range(99) >= IDLE_PCT);
      end
    end
  end

  always @(posedge clk_i) begin
    prediction_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (pending_predictions.size() == 0) begin
        report_mismatch("unexpected beat next_value", '0, m_axis_tdata[63:0]);
      end else begin
        want = pending_predictions.pop_front();
        if (m_axis_tdata[63:0] !== want.next_value) begin
          report_mismatch("next_value", want.next_value, m_axis_tdata[63:0]);
        end
        if (m_axis_tdata[127:64] !== want.running_sum) begin
          report_mismatch("running_sum", want.running_sum, m_axis_tdata[127:64]);
        end
        if (m_axis_tuser !== want.too_long) begin
          report_mismatch("too_long", DATA_W'(want.too_long), DATA_W'(m_axis_tuser));
        end
      end
    end
  end

  initial begin
    stim_row_t         row;
    logic [SAMPLE_W-1:0] smp;
    logic [SAMPLE_W-1:0] coef [5];
    logic [SAMPLE_W-1:0] acc;
    int unsigned       random_sent;
    int unsigned       seq_len;
    int unsigned       pick;
    int unsigned       degree;
    bit                held;
    bit                paused;

    rst_ni           = 1'b0;
    s_axis_tvalid    = 1'b0;
    s_axis_tdata     = '0;
    s_axis_tlast     = 1'b0;
    calm             = 1'b0;
    hold_req         = 1'b0;
    mismatches       = 0;
    kept_samples     = 0;
    dropped_sample   = 1'b0;
    prediction_total = '0;
    for (int k = 0; k < MAX_LEN; k++) begin
      diff_tail[k] = '0;
    end

    add_row(32'd5,          32'h0, 1,  1'b1, 1'b1, 64'd5, 64'd5, 1'b0);
    add_row(32'h7FFF_FFFF,  32'h0, 1,  1'b1, 1'b1, 64'd2147483647, 64'd2147483652, 1'b0);
    add_row(32'h8000_0000,  32'h0, 1,  1'b1, 1'b1, 64'hFFFF_FFFF_8000_0000, 64'd4, 1'b0);
    add_row(32'd1,          32'h0, 1,  1'b0, 1'b0, '0, '0, 1'b0);
    add_row(32'd2,          32'h0, 1,  1'b0, 1'b0, '0, '0, 1'b0);
    add_row(32'd3,          32'h0, 1,  1'b1, 1'b1, 64'd4, 64'd8, 1'b0);
    add_row(32'd9,          32'h0, 34, 1'b1, 1'b1, 64'd9, 64'd17, 1'b1);
    add_row(32'hFFFF_FFFF,  32'h0, 32, 1'b1, 1'b1, 64'hFFFF_FFFF_FFFF_FFFF, 64'd16, 1'b0);
    add_row(32'd10,         32'h0, 1,  1'b0, 1'b0, '0, '0, 1'b0);
    add_row(32'd20,         32'h0, 1,  1'b1, 1'b1, 64'd30, 64'd46, 1'b0);
    add_row(32'd0,          32'h0, 1,  1'b1, 1'b1, 64'd0, 64'd46, 1'b0);
    add_row(32'h7FFF_FFFF,  32'hFFFF_FFFF, 32, 1'b1, 1'b0, '0, '0, 1'b0);
    add_row(32'h1234_5678,  32'hA5A5_A5A5, 33, 1'b1, 1'b0, '0, '0, 1'b0);
    add_row(32'd1,          32'h0, 32, 1'b0, 1'b0, '0, '0, 1'b0);
    add_row(32'hDEAD_BEEF,  32'h0, 3,  1'b1, 1'b0, '0, '0, 1'b0);
    add_row(32'h8000_0000,  32'hFFFF_FFFF, 5, 1'b1, 1'b0, '0, '0, 1'b0);

    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    foreach (directed_rows[i]) begin
      row = directed_rows[i];
      smp = row.sample;
      for (int r = 0; r < row.reps; r++) begin
        send_sample(smp, row.ends_seq && (r == row.reps - 1), row.typed, row.known);
        smp = smp ^ row.flip;
      end
    end

    random_sent = 0;
    held        = 1'b0;
    paused      = 1'b0;
    while (random_sent < RANDOM_ITEMS) begin
      calm = (random_sent >= 150) && (random_sent < 350);
      if (!held && random_sent >= 450) begin
        hold_req = 1'b1;
        held     = 1'b1;
      end
      if (!paused && random_sent >= 750) begin
        @(negedge clk_i);
        s_axis_tvalid <= 1'b0;
        while (pending_predictions.size() != 0) @(posedge clk_i);
        paused = 1'b1;
      end
      pick = $urandom_range(99);
      if (pick < 65) begin
        seq_len = $urandom_range(12, 1);
        degree  = $urandom_range(4);
        coef[0] = ($urandom_range(3) == 0) ? $urandom : $urandom_range(2000) - 1000;
        for (int j = 1; j < 5; j++) begin
          coef[j] = (j <= degree) ? $urandom_range(512) - 256 : '0;
        end
        for (int n = 0; n < seq_len; n++) begin
          acc = coef[4];
          for (int j = 3; j >= 0; j--) begin
            acc = acc * n + coef[j];
          end
          send_sample(acc, n == seq_len - 1, 1'b0, '0);
        end
      end else begin
        if (pick < 82) begin
          seq_len = $urandom_range(MAX_LEN, 1);
        end else if (pick < 94) begin
          seq_len = $urandom_range(MAX_LEN + 8, MAX_LEN - 2);
        end else begin
          seq_len = 1;
        end
        for (int n = 0; n < seq_len; n++) begin
          send_sample($urandom, n == seq_len - 1, 1'b0, '0);
        end
      end
      random_sent += seq_len;
    end
    calm = 1'b0;

    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (pending_predictions.size() != 0) @(posedge clk_i);
    repeat (MAX_LEN + 8) @(posedge clk_i);

    if (mismatches == 0 && pending_predictions.size() == 0) begin
      $display("finite_difference_extrapolator test passed");
    end else begin
      $display("finite_difference_extrapolator test failed");
    end
    $finish;
  end

endmodule

[filelist.f]
src/fde_pkg.sv
src/fde_entry.sv
src/fde_cell.sv
src/finite_difference_extrapolator.sv
tb/finite_difference_extrapolator_tb.sv
